// ----- rtl/mmbd_pkg.sv -----
`default_nettype none
package mmbd_pkg;

	localparam int BUTTONS_DEF = 32;
	localparam int HATS_DEF    = 4;

	localparam logic [3:0] MODE_NORMAL   = 4'd0;
	localparam logic [3:0] MODE_INVERTED = 4'd1;
	localparam logic [3:0] MODE_TOGGLE   = 4'd2;
	localparam logic [3:0] MODE_SW_BOTH  = 4'd3;
	localparam logic [3:0] MODE_SW_ON    = 4'd4;
	localparam logic [3:0] MODE_SW_OFF   = 4'd5;
	localparam logic [3:0] MODE_HAT      = 4'd6;
	localparam logic [3:0] MODE_RADIO    = 4'd7;
	localparam logic [3:0] MODE_SEQ      = 4'd8;
	localparam logic [3:0] MODE_UNSET    = 4'd15;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_PULSE    = 1'b1;

	localparam logic [15:0] DEBOUNCE_RST = 16'd10;
	localparam logic [15:0] PULSE_RST    = 16'd100;

	typedef struct packed {
		logic load;
		logic eval;
		logic radio;
		logic seq_dn;
		logic seq_up;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic bad_idx;
		logic go_radio;
		logic go_seq_dn;
		logic go_seq_up;
		logic radio_end;
		logic dn_end;
		logic dn_up;
		logic up_end;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/mmbd_datapath.sv -----
`default_nettype none
module mmbd_datapath #(
	parameter int BUTTONS = mmbd_pkg::BUTTONS_DEF,
	parameter int HATS    = mmbd_pkg::HATS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mmbd_pkg::cmd_t      cmd,
	output mmbd_pkg::sts_t      sts,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [15:0]         cfg_data,
	input  wire  [4:0]          button_index,
	input  wire  [3:0]          mode,
	input  wire  [4:0]          group,
	input  wire  [1:0]          direction,
	input  wire                 pin_level,
	input  wire  [31:0]         time_ms,
	output logic [4:0]          out_index,
	output logic                logical_state,
	output logic [7:0]          press_count,
	output logic [31:0]         pressed_map,
	output logic [15:0]         hat_bits
);
	import mmbd_pkg::*;

	localparam int NREC = (BUTTONS < 32) ? BUTTONS : 32;
	localparam int IW   = $clog2(NREC);
	localparam logic [IW-1:0] KLAST = IW'(NREC - 1);

	logic [15:0]   debounce_q, pulse_q;
	logic [4:0]    idx_q, group_q;
	logic [3:0]    mode_q;
	logic [1:0]    dir_q;
	logic          pinraw_q, pin_q, first_q;
	logic [31:0]   t_q;
	logic [IW-1:0] k_q;

	logic [NREC-1:0] raw_q, logical_q, pend_q;
	logic [31:0]     stamp_q [NREC];
	logic [7:0]      pres_q [NREC];
	logic [3:0]      smode_q [NREC];
	logic [4:0]      sgroup_q [NREC];
	logic [15:0]     hat_q;

	logic [IW-1:0] ia;
	logic          pin, rp, lg, pd, deb, pul, edge_ok;
	logic [31:0]   st, dt;
	logic [7:0]    pr;
	logic          n_rp, n_lg, n_pd, go_r, go_s;
	logic [31:0]   n_st;
	logic [7:0]    n_pr;
	logic [15:0]   n_hat, hbit;
	logic [3:0]    want;
	logic          peer, takeable, first_n, take_dn, take_up;

	assign ia  = idx_q[IW-1:0];
	assign pin = pinraw_q ^ (mode_q == MODE_INVERTED);
	assign rp  = raw_q[ia];
	assign lg  = logical_q[ia];
	assign pd  = pend_q[ia];
	assign st  = stamp_q[ia];
	assign pr  = pres_q[ia];
	assign dt  = t_q - st;
	assign deb = dt > {16'd0, debounce_q};
	assign pul = dt > {16'd0, pulse_q};
	assign hbit = 16'(4'b0001 << dir_q) << {group_q[1:0], 2'b00};

	always_comb begin
		n_rp = rp;
		n_lg = lg;
		n_pd = pd;
		n_st = st;
		n_pr = pr;
		n_hat = hat_q;
		go_r = 1'b0;
		go_s = 1'b0;
		edge_ok = 1'b0;
		unique case (mode_q)
			MODE_NORMAL, MODE_INVERTED, MODE_HAT: begin
				if (!pd && pin != rp) begin
					n_st = t_q;
					n_pd = 1'b1;
				end else if (pd && pin != rp && deb) begin
					n_pd = 1'b0;
					n_rp = pin;
					n_pr = pr + {7'd0, pin};
					if (mode_q != MODE_HAT) begin
						n_lg = pin;
					end else if (32'(group_q) < 32'(HATS)) begin
						n_hat = pin ? (hat_q | hbit) : (hat_q & ~hbit);
					end
				end else if (pd && deb) begin
					n_pd = 1'b0;
				end
			end
			MODE_TOGGLE, MODE_RADIO: begin
				if (!pd && pin && !rp) begin
					n_st = t_q;
					n_pd = 1'b1;
				end else if (pd && pin && deb) begin
					n_pd = 1'b0;
					n_rp = 1'b1;
					n_pr = pr + 8'd1;
					if (mode_q == MODE_TOGGLE) begin
						n_lg = !lg;
					end else begin
						n_lg = 1'b1;
						go_r = 1'b1;
					end
				end else if (!pin && deb) begin
					n_pd = 1'b0;
					n_rp = 1'b0;
				end
			end
			MODE_SW_BOTH, MODE_SW_ON, MODE_SW_OFF: begin
				if (mode_q == MODE_SW_BOTH) edge_ok = pin != rp;
				else if (mode_q == MODE_SW_ON) edge_ok = pin && !rp;
				else edge_ok = !pin && rp;
				if (!pd && pin != rp) begin
					n_st = t_q;
					n_pd = 1'b1;
				end else if (pd && edge_ok && deb) begin
					n_pd = 1'b0;
					n_lg = 1'b1;
					n_rp = pin;
					n_pr = pr + 8'd1;
				end else if (pul) begin
					if (mode_q != MODE_SW_BOTH) n_rp = pin;
					n_lg = 1'b0;
					n_pd = 1'b0;
				end
			end
			MODE_SEQ: begin
				if (!pd && pin && !rp) begin
					n_st = t_q;
					n_pd = 1'b1;
				end else if (pd && pin && deb) begin
					n_pd = 1'b0;
					go_s = 1'b1;
				end else if (!pin && deb) begin
					n_pd = 1'b0;
					n_rp = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// scan of peer records at k
	assign want     = cmd.radio ? MODE_RADIO : MODE_SEQ;
	assign peer     = smode_q[k_q] == want && sgroup_q[k_q] == group_q;
	assign takeable = logical_q[k_q] && !raw_q[k_q];
	assign first_n  = first_q && !peer;
	assign take_dn  = peer && takeable;
	assign take_up  = peer && logical_q[k_q] && !raw_q[k_q];

	always_comb begin
		sts.bad_idx   = 32'(idx_q) >= 32'(BUTTONS);
		sts.go_radio  = go_r;
		sts.go_seq_dn = go_s && ia != '0;
		sts.go_seq_up = go_s && ia == '0 && !lg;
		sts.radio_end = k_q == KLAST;
		sts.dn_end    = take_dn || (k_q == '0 && !(first_n && !lg && ia != KLAST));
		sts.dn_up     = !take_dn && k_q == '0 && first_n && !lg && ia != KLAST;
		sts.up_end    = (peer && (!logical_q[k_q] || !raw_q[k_q])) || k_q == ia + IW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			pulse_q <= PULSE_RST;
			raw_q <= '0;
			logical_q <= '0;
			pend_q <= '0;
			hat_q <= '0;
			for (int i = 0; i < NREC; i++) begin
				stamp_q[i] <= '0;
				pres_q[i] <= '0;
				smode_q[i] <= MODE_UNSET;
				sgroup_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DEBOUNCE) debounce_q <= cfg_data;
				else pulse_q <= cfg_data;
			end
			if (cmd.eval) begin
				smode_q[ia] <= mode_q;
				sgroup_q[ia] <= group_q;
				raw_q[ia] <= n_rp;
				logical_q[ia] <= n_lg;
				pend_q[ia] <= n_pd;
				stamp_q[ia] <= n_st;
				pres_q[ia] <= n_pr;
				hat_q <= n_hat;
			end
			if (cmd.radio && peer && k_q != ia) begin
				logical_q[k_q] <= 1'b0;
			end
			if ((cmd.seq_dn && take_dn) || (cmd.seq_up && take_up)) begin
				logical_q[k_q] <= 1'b0;
				logical_q[ia] <= 1'b1;
				raw_q[ia] <= pin_q;
				stamp_q[ia] <= t_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= button_index;
			mode_q <= mode;
			group_q <= group;
			dir_q <= direction;
			pinraw_q <= pin_level;
			t_q <= time_ms;
		end
		if (cmd.eval) begin
			pin_q <= pin;
			first_q <= 1'b1;
			if (go_r) k_q <= '0;
			else if (ia == '0) k_q <= KLAST;
			else k_q <= ia - IW'(1);
		end
		if (cmd.radio) k_q <= k_q + IW'(1);
		if (cmd.seq_dn) begin
			first_q <= first_n;
			k_q <= sts.dn_up ? KLAST : k_q - IW'(1);
		end
		if (cmd.seq_up) k_q <= k_q - IW'(1);
		if (cmd.fin) begin
			out_index <= idx_q;
			logical_state <= sts.bad_idx ? 1'b0 : lg;
			press_count <= sts.bad_idx ? 8'd0 : pr;
			pressed_map <= 32'(logical_q);
			hat_bits <= hat_q;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mmbd_ctrl.sv -----
`default_nettype none
module mmbd_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	input  mmbd_pkg::sts_t sts,
	output mmbd_pkg::cmd_t cmd
);
	import mmbd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EVAL   = 6'b000010,
		S_RADIO  = 6'b000100,
		S_SEQ_DN = 6'b001000,
		S_SEQ_UP = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.bad_idx) begin
					state_d = S_FIN;
				end else begin
					cmd.eval = 1'b1;
					if (sts.go_radio) state_d = S_RADIO;
					else if (sts.go_seq_dn) state_d = S_SEQ_DN;
					else if (sts.go_seq_up) state_d = S_SEQ_UP;
					else state_d = S_FIN;
				end
			end
			S_RADIO: begin
				cmd.radio = 1'b1;
				if (sts.radio_end) state_d = S_FIN;
			end
			S_SEQ_DN: begin
				cmd.seq_dn = 1'b1;
				if (sts.dn_up) state_d = S_SEQ_UP;
				else if (sts.dn_end) state_d = S_FIN;
			end
			S_SEQ_UP: begin
				cmd.seq_up = 1'b1;
				if (sts.up_end) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/multimode_button_debouncer.sv -----
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    button_index mode group direction pin_level time_ms
// out      output     out_valid / out_ready  out_index logical_state press_count pressed_map hat_bits
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// one word at a time: accept, evaluate (skipped for a bad index), optional group scan, finish
// radio scans every record; sequential walks the records below the button,
// then those above it when no peer was found below
// the scan visits one record per cycle and checks it for a peer
// reset clears all records at once; no clearing pass
// a waiting result holds the finish step; no new word is accepted meanwhile
`default_nettype none
module multimode_button_debouncer #(
	parameter int BUTTONS = mmbd_pkg::BUTTONS_DEF,
	parameter int HATS    = mmbd_pkg::HATS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [4:0]  button_index,
	input  wire  [3:0]  mode,
	input  wire  [4:0]  group,
	input  wire  [1:0]  direction,
	input  wire         pin_level,
	input  wire  [31:0] time_ms,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [4:0]  out_index,
	output logic        logical_state,
	output logic [7:0]  press_count,
	output logic [31:0] pressed_map,
	output logic [15:0] hat_bits,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);
	import mmbd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mmbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mmbd_datapath #(
		.BUTTONS (BUTTONS),
		.HATS    (HATS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.button_index  (button_index),
		.mode          (mode),
		.group         (group),
		.direction     (direction),
		.pin_level     (pin_level),
		.time_ms       (time_ms),
		.out_index     (out_index),
		.logical_state (logical_state),
		.press_count   (press_count),
		.pressed_map   (pressed_map),
		.hat_bits      (hat_bits)
	);

endmodule
`default_nettype wire

// ----- dv/tb_multimode_button_debouncer.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_multimode_button_debouncer;
	import mmbd_pkg::*;

	localparam int NBTN = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [4:0]  idx;
		logic [3:0]  mode;
		logic [4:0]  grp;
		logic [1:0]  dir;
		logic        pin;
		logic [31:0] tms;
	} sample_t;

	typedef struct packed {
		logic [4:0]  idx;
		logic        lstate;
		logic [7:0]  count;
		logic [31:0] map;
		logic [15:0] hats;
	} status_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [4:0] button_index;
	logic [3:0] mode;
	logic [4:0] group;
	logic [1:0] direction;
	logic pin_level;
	logic [31:0] time_ms;
	logic out_valid, out_ready;
	logic [4:0] out_index;
	logic logical_state;
	logic [7:0] press_count;
	logic [31:0] pressed_map;
	logic [15:0] hat_bits;
	logic cfg_valid, cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	multimode_button_debouncer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.button_index(button_index), .mode(mode), .group(group),
		.direction(direction), .pin_level(pin_level), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_index(out_index), .logical_state(logical_state),
		.press_count(press_count), .pressed_map(pressed_map), .hat_bits(hat_bits),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// debouncer shadow state
	logic [15:0] deb_ms, pul_ms;
	logic        b_raw [NBTN];
	logic        b_log [NBTN];
	logic        b_pend [NBTN];
	logic [31:0] b_stamp [NBTN];
	logic [7:0]  b_cnt [NBTN];
	logic [3:0]  b_mode [NBTN];
	logic [4:0]  b_grp [NBTN];
	logic [15:0] hat_reg;

	sample_t pending_words[$];
	status_t expected_status[$];
	int errors;
	int idle_cycles;
	logic driver_done;

	function automatic bit is_member(int i, logic [3:0] m, logic [4:0] g);
		return b_mode[i] == m && b_grp[i] == g;
	endfunction

	function automatic void seq_handover(int from, int to, logic p, logic [31:0] t);
		b_log[from] = 1'b0;
		b_log[to] = 1'b1;
		b_raw[to] = p;
		b_stamp[to] = t;
	endfunction

	function automatic status_t debounce_step(sample_t s);
		status_t r;
		int id;
		logic p;
		logic [31:0] dt;
		bit dover, pover, edge_ok, first;
		logic [15:0] hb;
		id = s.idx;
		p = s.pin;
		r = '0;
		r.idx = s.idx;
		b_mode[id] = s.mode;
		b_grp[id] = s.grp;
		if (s.mode == MODE_INVERTED)
			p = ~p;
		dt = s.tms - b_stamp[id];
		dover = dt > {16'd0, deb_ms};
		pover = dt > {16'd0, pul_ms};
		case (s.mode)
			MODE_NORMAL, MODE_INVERTED, MODE_HAT: begin
				if (!b_pend[id] && p != b_raw[id]) begin
					b_stamp[id] = s.tms;
					b_pend[id] = 1'b1;
				end else if (b_pend[id] && p != b_raw[id] && dover) begin
					b_pend[id] = 1'b0;
					b_raw[id] = p;
					b_cnt[id] = b_cnt[id] + {7'd0, p};
					if (s.mode != MODE_HAT) begin
						b_log[id] = p;
					end else if (s.grp < HATS_DEF) begin
						hb = 16'(4'b0001 << s.dir) << (4 * s.grp);
						hat_reg = p ? (hat_reg | hb) : (hat_reg & ~hb);
					end
				end else if (b_pend[id] && dover) begin
					b_pend[id] = 1'b0;
				end
			end
			MODE_TOGGLE, MODE_RADIO: begin
				if (!b_pend[id] && p && !b_raw[id]) begin
					b_stamp[id] = s.tms;
					b_pend[id] = 1'b1;
				end else if (b_pend[id] && p && dover) begin
					b_pend[id] = 1'b0;
					b_raw[id] = 1'b1;
					b_cnt[id]++;
					if (s.mode == MODE_TOGGLE) begin
						b_log[id] = ~b_log[id];
					end else begin
						b_log[id] = 1'b1;
						for (int i = 0; i < NBTN; i++)
							if (i != id && is_member(i, MODE_RADIO, s.grp))
								b_log[i] = 1'b0;
					end
				end else if (!p && dover) begin
					b_pend[id] = 1'b0;
					b_raw[id] = 1'b0;
				end
			end
			MODE_SW_BOTH, MODE_SW_ON, MODE_SW_OFF: begin
				if (s.mode == MODE_SW_BOTH)
					edge_ok = p != b_raw[id];
				else if (s.mode == MODE_SW_ON)
					edge_ok = p && !b_raw[id];
				else
					edge_ok = !p && b_raw[id];
				if (!b_pend[id] && p != b_raw[id]) begin
					b_stamp[id] = s.tms;
					b_pend[id] = 1'b1;
				end else if (b_pend[id] && edge_ok && dover) begin
					b_pend[id] = 1'b0;
					b_log[id] = 1'b1;
					b_raw[id] = p;
					b_cnt[id]++;
				end else if (pover) begin
					if (s.mode != MODE_SW_BOTH)
						b_raw[id] = p;
					b_log[id] = 1'b0;
					b_pend[id] = 1'b0;
				end
			end
			MODE_SEQ: begin
				if (!b_pend[id] && p && !b_raw[id]) begin
					b_stamp[id] = s.tms;
					b_pend[id] = 1'b1;
				end else if (b_pend[id] && p && dover) begin
					first = 1;
					b_pend[id] = 1'b0;
					for (int k = id - 1; k >= 0; k--) begin
						if (is_member(k, MODE_SEQ, s.grp)) begin
							first = 0;
							if (b_log[k] && !b_raw[k]) begin
								seq_handover(k, id, p, s.tms);
								break;
							end
						end
					end
					if (first && !b_log[id]) begin
						for (int k = NBTN - 1; k > id; k--) begin
							if (is_member(k, MODE_SEQ, s.grp)) begin
								if (!b_log[k])
									break;
								if (!b_raw[k]) begin
									seq_handover(k, id, p, s.tms);
									break;
								end
							end
						end
					end
				end else if (!p && dover) begin
					b_pend[id] = 1'b0;
					b_raw[id] = 1'b0;
				end
			end
			default: ;
		endcase
		r.lstate = b_log[id];
		r.count = b_cnt[id];
		for (int i = 0; i < NBTN; i++)
			r.map[i] = b_log[i];
		r.hats = hat_reg;
		return r;
	endfunction

	// driver
	int gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_status.push_back(debounce_step(pending_words.pop_front()));
			end
			if (!(in_valid && !in_ready)) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && !driver_done) begin
					in_valid <= 1'b1;
					button_index <= pending_words[0].idx;
					mode <= pending_words[0].mode;
					group <= pending_words[0].grp;
					direction <= pending_words[0].dir;
					pin_level <= pending_words[0].pin;
					time_ms <= pending_words[0].tms;
					gap = ($urandom_range(0, 3) == 0) ?
						(($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) :
						$urandom_range(1, 3)) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	status_t got, exp_s;
	int stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {out_index, logical_state, press_count, pressed_map, hat_bits};
				if (expected_status.size() == 0) begin
					$display("%0t unexpected word %h", $time, got);
					errors++;
				end else begin
					exp_s = expected_status.pop_front();
					if (exp_s.idx !== got.idx) begin
						$display("%0t out_index exp %0d got %0d", $time, exp_s.idx, got.idx);
						errors++;
					end
					if (exp_s.lstate !== got.lstate) begin
						$display("%0t logical_state exp %0d got %0d", $time,
							exp_s.lstate, got.lstate);
						errors++;
					end
					if (exp_s.count !== got.count) begin
						$display("%0t press_count exp %0d got %0d", $time,
							exp_s.count, got.count);
						errors++;
					end
					if (exp_s.map !== got.map) begin
						$display("%0t pressed_map exp %h got %h", $time, exp_s.map, got.map);
						errors++;
					end
					if (exp_s.hats !== got.hats) begin
						$display("%0t hat_bits exp %h got %h", $time, exp_s.hats, got.hats);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	logic [31:0] clock_ms;

	task automatic add_word(int idx, logic [3:0] m, int g, int d, logic p, logic [31:0] t);
		sample_t s;
		s.idx = 5'(idx);
		s.mode = m;
		s.grp = 5'(g);
		s.dir = 2'(d);
		s.pin = p;
		s.tms = t;
		pending_words.push_back(s);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || expected_status.size() > 0 || in_valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic ri, logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (ri == REG_DEBOUNCE)
			deb_ms = v;
		else
			pul_ms = v;
		cfg_valid <= 1'b0;
	endtask

	// press or release: one level held over 2 to 4 words with random time steps
	task automatic add_gesture(int idx, logic [3:0] m, int g, int d, logic p);
		int n;
		n = $urandom_range(2, 4);
		for (int k = 0; k < n; k++) begin
			clock_ms += $urandom_range(0, 2 * deb_ms + 4);
			add_word(idx, m, g, d, p, clock_ms);
		end
	endtask

	logic [3:0] seq_modes[9] = '{MODE_NORMAL, MODE_INVERTED, MODE_TOGGLE, MODE_SW_BOTH,
		MODE_SW_ON, MODE_SW_OFF, MODE_HAT, MODE_RADIO, MODE_SEQ};
	logic [3:0] btn_mode[NBTN];
	logic [4:0] btn_grp[NBTN];
	logic [1:0] btn_dir[NBTN];

	initial begin
		int total;
		errors = 0;
		idle_cycles = 0;
		driver_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		button_index = '0;
		mode = '0;
		group = '0;
		direction = '0;
		pin_level = 1'b0;
		time_ms = '0;
		deb_ms = DEBOUNCE_RST;
		pul_ms = PULSE_RST;
		hat_reg = '0;
		for (int i = 0; i < NBTN; i++) begin
			b_raw[i] = 0; b_log[i] = 0; b_pend[i] = 0; b_stamp[i] = '0;
			b_cnt[i] = '0; b_mode[i] = MODE_UNSET; b_grp[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		clock_ms = 32'hFFFF_FF00;

		// directed: every mode, extremes, wrap of time, bad hat number
		for (int m = 0; m < 16; m++) begin
			add_word(m, 4'(m), m == 6 ? 4 : 31, 3, 1'b1, clock_ms);
			add_word(m, 4'(m), m == 6 ? 4 : 31, 3, 1'b1, clock_ms + 200);
		end
		add_word(31, MODE_HAT, 3, 3, 1'b1, 32'hFFFF_FFFF);
		add_word(31, MODE_HAT, 3, 3, 1'b1, 32'd50);
		add_word(0, MODE_HAT, 0, 0, 1'b1, 32'd0);
		add_word(0, MODE_HAT, 0, 0, 1'b1, 32'd100);
		add_word(0, MODE_NORMAL, 0, 0, 1'b0, 32'hFFFF_FFFF);
		drain();

		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_PULSE, 16'd0);
		for (int k = 0; k < 20; k++)
			add_word($urandom_range(0, 31), 4'($urandom_range(0, 15)), $urandom_range(0, 31),
				$urandom_range(0, 3), 1'($urandom_range(0, 1)), $urandom());
		drain();
		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_PULSE, 16'hFFFF);
		for (int k = 0; k < 20; k++)
			add_word($urandom_range(0, 31), 4'($urandom_range(0, 15)), $urandom_range(0, 31),
				$urandom_range(0, 3), 1'($urandom_range(0, 1)), $urandom());
		drain();

		// random phases with a fixed button assignment each
		total = 0;
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_DEBOUNCE, 16'($urandom_range(1, 20)));
			write_reg(REG_PULSE, 16'($urandom_range(5, 60)));
			for (int i = 0; i < NBTN; i++) begin
				btn_mode[i] = seq_modes[$urandom_range(0, 8)];
				btn_grp[i] = 5'($urandom_range(0, 5) == 0 ? $urandom_range(0, 31) :
					$urandom_range(0, 3));
				btn_dir[i] = 2'($urandom_range(0, 3));
			end
			while (total < (ph + 1) * 190) begin
				int b;
				b = $urandom_range(0, 31);
				if ($urandom_range(0, 9) == 0) begin
					clock_ms += $urandom_range(0, 3);
					add_word(b, 4'($urandom_range(0, 15)), $urandom_range(0, 31),
						$urandom_range(0, 3), 1'($urandom_range(0, 1)),
						$urandom_range(0, 7) == 0 ? $urandom() : clock_ms);
					total++;
				end else begin
					add_gesture(b, btn_mode[b], btn_grp[b], btn_dir[b],
						1'($urandom_range(0, 1)));
					total += 3;
				end
				if (ph == 2 && total > 500 && total < 505) begin
					while (pending_words.size() > 0 || in_valid)
						@(posedge clk);
					while (expected_status.size() > 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/mmbd_pkg.sv
rtl/mmbd_datapath.sv
rtl/mmbd_ctrl.sv
rtl/multimode_button_debouncer.sv
dv/tb_multimode_button_debouncer.sv
